[hdl/hsi_pkg.sv]
// Package: shared types, constants and helpers for the hash set block.
package hsi_pkg;

  localparam int NumBuckets  = 64;
  localparam int BucketDepth = 8;
  localparam int HashW       = 64;
  localparam int TotalW      = 10;
  localparam int CountW      = 7;

  localparam logic [TotalW-1:0] TotalMax = '1;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_LOOKUP = 1'b1
  } cmd_t;

  typedef struct packed {
    logic              cmd;
    logic signed [7:0] char_value;
    logic              last_char;
    logic              key_empty;
    logic              allow_repeats;
  } in_beat_t;

  typedef struct packed {
    logic        found;
    logic        inserted;
    logic        bucket_full;
    logic [5:0]  bucket_index;
    logic [9:0]  entry_total;
  } out_beat_t;

  // One finished key handed from the front end to the back end.
  typedef struct packed {
    logic             cmd;
    logic             allow_repeats;
    logic [HashW-1:0] hash;
  } key_job_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_FILL,
    ST_SCAN,
    ST_WRITE,
    ST_DONE
  } back_state_t;

  // Fold one character: hash * 31 xor sign extended character.
  function automatic logic [HashW-1:0] fold_char(input logic [HashW-1:0] h,
                                                 input logic [7:0] c);
    logic [HashW-1:0] m;
    m = (h << 5) - h;
    return m ^ {{(HashW-8){c[7]}}, c};
  endfunction

endpackage

[hdl/hsi_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
module hsi_ram #(
  parameter int Width = 64,
  parameter int Depth = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/hsi_front.sv]
// Front end: fold characters into the running hash and emit finished keys.
module hsi_front (
  input  logic                     clk,
  input  logic                     rst,
  input  hsi_pkg::in_beat_t        in_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  output hsi_pkg::key_job_t        job,
  output logic                     job_valid,
  input  logic                     job_stall
);

  logic [hsi_pkg::HashW-1:0] acc;
  logic [hsi_pkg::HashW-1:0] folded;
  logic                      take;
  logic                      finish;

  // Stall only when a finished key is waiting and the queue is full.
  assign in_stall = job_valid && job_stall;
  assign take     = in_valid && !in_stall;
  assign folded   = hsi_pkg::fold_char(acc, in_data.char_value);
  assign finish   = in_data.key_empty || in_data.last_char;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      job_valid <= 1'b0;
    end else begin
      if (take && finish) begin
        job_valid <= 1'b1;
      end else if (job_valid && !job_stall) begin
        job_valid <= 1'b0;
      end
      if (take) begin
        if (finish) begin
          acc <= '0;
        end else begin
          acc <= folded;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && finish) begin
      job.cmd           <= in_data.cmd;
      job.allow_repeats <= in_data.allow_repeats;
      job.hash          <= in_data.key_empty ? '0 : folded;
    end
  end

endmodule

[hdl/hsi_queue.sv]
// Two-entry queue between the front and back ends.
module hsi_queue (
  input  logic              clk,
  input  logic              rst,
  input  hsi_pkg::key_job_t in_job,
  input  logic              in_valid,
  output logic              in_stall,
  output hsi_pkg::key_job_t out_job,
  output logic              out_valid,
  input  logic              out_stall
);

  hsi_pkg::key_job_t slot [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       push;
  logic       pop;

  assign in_stall  = cnt[1];
  assign out_valid = cnt != 2'd0;
  assign out_job   = slot[rp];
  assign push      = in_valid && !in_stall;
  assign pop       = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= '0;
    end else begin
      if (push) wp <= !wp;
      if (pop) rp <= !rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wp] <= in_job;
    end
  end

endmodule

[hdl/hsi_back.sv]
// Back end: bucket select by restoring division, bucket scan, insert, result.
module hsi_back #(
  parameter int NumBuckets  = hsi_pkg::NumBuckets,
  parameter int BucketDepth = hsi_pkg::BucketDepth
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [hsi_pkg::CountW-1:0] bucket_count,
  input  hsi_pkg::key_job_t          job,
  input  logic                       job_valid,
  output logic                       job_stall,
  output hsi_pkg::out_beat_t         out_data,
  output logic                       out_valid,
  input  logic                       out_stall
);

  localparam int BW    = (NumBuckets > 1) ? $clog2(NumBuckets) : 1;
  localparam int SW    = (BucketDepth > 1) ? $clog2(BucketDepth) : 1;
  localparam int FW    = $clog2(BucketDepth + 1);
  localparam int DW    = $clog2(NumBuckets + 1);
  localparam int RW    = DW + 1;
  localparam int AW    = BW + SW;
  localparam int HW    = hsi_pkg::HashW;
  localparam int CW    = $clog2(HW);
  localparam int BPC   = 4; // quotient bits per cycle

  hsi_pkg::back_state_t state, state_next;

  logic [HW-1:0]  hash;
  logic           cmd;
  logic           rep;
  logic [DW-1:0]  divisor;
  logic [HW-1:0]  dividend;
  logic [RW-1:0]  rem;
  logic [CW-1:0]  bit_cnt;
  logic [BW-1:0]  idx;
  logic [FW-1:0]  fill;
  logic [SW-1:0]  scan;
  logic           found;
  logic [hsi_pkg::TotalW-1:0] total;
  logic [FW-1:0]  fill_tab [NumBuckets];
  logic [RW-1:0]  rem_next;
  logic [HW-1:0]  dividend_next;
  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  logic [AW-1:0]  ram_raddr;
  logic [HW-1:0]  ram_rdata;
  logic           scan_pending;
  logic           do_store;
  logic           is_full;

  // Restoring division, BPC bits of the 64-bit dividend per cycle.
  always_comb begin
    logic [RW-1:0] r;
    logic [HW-1:0] d;
    r = rem;
    d = dividend;
    for (int k = 0; k < BPC; k++) begin
      r = {r[RW-2:0], d[HW-1]};
      d = {d[HW-2:0], 1'b0};
      if (r >= RW'(divisor)) r = r - RW'(divisor);
    end
    rem_next      = r;
    dividend_next = d;
  end

  assign ram_raddr = {idx, scan};
  assign is_full   = fill >= FW'(BucketDepth);
  assign do_store  = (cmd == hsi_pkg::CMD_INSERT) && !(found && !rep) && !is_full;
  assign ram_we    = (state == hsi_pkg::ST_WRITE) && do_store;
  assign ram_waddr = {idx, SW'(fill)};

  hsi_ram #(.Width(HW), .Depth(NumBuckets * (1 << SW))) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (hash),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next = state;
    job_stall  = 1'b1;
    unique case (state)
      hsi_pkg::ST_IDLE: begin
        job_stall = 1'b0;
        if (job_valid) state_next = hsi_pkg::ST_MOD;
      end
      hsi_pkg::ST_MOD: begin
        if (bit_cnt == CW'(HW - BPC)) state_next = hsi_pkg::ST_FILL;
      end
      hsi_pkg::ST_FILL: begin
        state_next = (fill_tab[idx] == '0) ? hsi_pkg::ST_WRITE : hsi_pkg::ST_SCAN;
      end
      hsi_pkg::ST_SCAN: begin
        if (!scan_pending && (FW'(scan) + FW'(1) >= fill)) state_next = hsi_pkg::ST_WRITE;
      end
      hsi_pkg::ST_WRITE: begin
        state_next = hsi_pkg::ST_DONE;
      end
      hsi_pkg::ST_DONE: begin
        if (!out_stall) state_next = hsi_pkg::ST_IDLE;
      end
      default: state_next = hsi_pkg::ST_IDLE;
    endcase
  end

  assign out_valid = state == hsi_pkg::ST_DONE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hsi_pkg::ST_IDLE;
      total <= '0;
      for (int b = 0; b < NumBuckets; b++) fill_tab[b] <= '0;
    end else begin
      state <= state_next;
      if (ram_we) begin
        fill_tab[idx] <= fill + FW'(1);
        if (total != hsi_pkg::TotalMax) total <= total + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      hsi_pkg::ST_IDLE: begin
        hash     <= job.hash;
        cmd      <= job.cmd;
        rep      <= job.allow_repeats;
        dividend <= job.hash;
        rem      <= '0;
        bit_cnt  <= '0;
        found    <= 1'b0;
        if (bucket_count == '0) begin
          divisor <= DW'(1);
        end else if (32'(bucket_count) > NumBuckets) begin
          divisor <= DW'(NumBuckets);
        end else begin
          divisor <= DW'(bucket_count);
        end
      end
      hsi_pkg::ST_MOD: begin
        rem      <= rem_next;
        dividend <= dividend_next;
        bit_cnt  <= bit_cnt + CW'(BPC);
        idx      <= BW'(rem_next);
        scan     <= '0;
      end
      hsi_pkg::ST_FILL: begin
        fill         <= fill_tab[idx];
        scan_pending <= 1'b1;
      end
      hsi_pkg::ST_SCAN: begin
        // Read data is registered, so it arrives in the cycle after the address.
        scan_pending <= !scan_pending;
        if (!scan_pending) begin
          if (ram_rdata == hash) found <= 1'b1;
          scan <= scan + SW'(1);
        end
      end
      hsi_pkg::ST_WRITE: begin
        out_data.found        <= found;
        out_data.inserted     <= do_store;
        out_data.bucket_full  <= (cmd == hsi_pkg::CMD_INSERT) && !(found && !rep) && is_full;
        out_data.bucket_index <= 6'(idx);
        out_data.entry_total  <= (do_store && total != hsi_pkg::TotalMax) ? total + 1'b1 : total;
      end
      default: begin
      end
    endcase
  end

endmodule

[hdl/hash_set_insert_lookup.sv]
// Top level of the hash set: front end, key queue and back end.
//
// Keys arrive one character a beat; the front end folds each beat into a
// 64-bit hash (times 31, xor sign-extended character), so characters stream
// at one beat a cycle unless the key queue is full and a finished key waits.
// A finished key (last_char or key_empty) goes through a two-entry queue to
// the back end, which reduces the hash modulo the active bucket count by
// restoring division, 4 bits a cycle, reads the bucket fill count, scans the
// filled slots of the bucket memory (one registered read port), then stores
// and reports. It takes no new key until it has reported the last; the front
// end keeps taking characters of the next key meanwhile, until the queue is
// full. One result beat per finished key. bucket_count reads 0 as 1 and
// saturates at NUM_BUCKETS; write it only while idle.
module hash_set_insert_lookup #(
  parameter int NUM_BUCKETS  = hsi_pkg::NumBuckets,
  parameter int BUCKET_DEPTH = hsi_pkg::BucketDepth
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [hsi_pkg::CountW-1:0] cfg_wdata,
  input  hsi_pkg::in_beat_t        in_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  output hsi_pkg::out_beat_t       out_data,
  output logic                     out_valid,
  input  logic                     out_stall
);

  logic [hsi_pkg::CountW-1:0] bucket_count;
  hsi_pkg::key_job_t f_job, q_job;
  logic f_valid, f_stall, q_valid, q_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count <= hsi_pkg::CountW'(64);
    end else if (cfg_we) begin
      bucket_count <= cfg_wdata;
    end
  end

  hsi_front u_front (
    .clk(clk), .rst(rst), .in_data(in_data), .in_valid(in_valid),
    .in_stall(in_stall), .job(f_job), .job_valid(f_valid), .job_stall(f_stall)
  );

  hsi_queue u_queue (
    .clk(clk), .rst(rst), .in_job(f_job), .in_valid(f_valid), .in_stall(f_stall),
    .out_job(q_job), .out_valid(q_valid), .out_stall(q_stall)
  );

  hsi_back #(.NumBuckets(NUM_BUCKETS), .BucketDepth(BUCKET_DEPTH)) u_back (
    .clk(clk), .rst(rst), .bucket_count(bucket_count), .job(q_job),
    .job_valid(q_valid), .job_stall(q_stall), .out_data(out_data),
    .out_valid(out_valid), .out_stall(out_stall)
  );

endmodule
